@@ hdl/rmq_pkg.sv @@
// shared constants, types and slot codes for the matrix to quaternion pipeline
`default_nettype none
package rmq_pkg;

    localparam int DATA_WIDTH = 16;
    localparam int FRAC_W     = DATA_WIDTH - 2;
    localparam int ELEMS      = 9;
    localparam int QUATS      = 4;
    localparam int IN_W       = ELEMS * DATA_WIDTH;
    localparam int OUT_W      = QUATS * DATA_WIDTH;
    localparam int TR_W       = DATA_WIDTH + 2;
    localparam int EXT_W      = DATA_WIDTH + 3;
    localparam int RAD_W      = DATA_WIDTH + 1;
    localparam int MAG_W      = DATA_WIDTH + 1;
    localparam int SQ_IN_W    = RAD_W + FRAC_W - 2;
    localparam int SQ_STEPS   = (SQ_IN_W + 1) / 2;
    localparam int SQ_PAD_W   = 2 * SQ_STEPS;
    localparam int ROOT_W     = SQ_STEPS;
    localparam int SQ_REM_W   = ROOT_W + 3;
    localparam int NUM_W      = MAG_W + FRAC_W - 1;
    localparam int QUO_W      = NUM_W;
    localparam int DREM_W     = ROOT_W + 1;

    localparam logic signed [EXT_W-1:0] Q_ONE_X = EXT_W'(1) << FRAC_W;
    localparam logic [QUO_W-1:0] Q_MAX_U = QUO_W'((64'd1 << (DATA_WIDTH - 1)) - 64'd1);
    localparam logic [QUO_W-1:0] Q_MIN_U = QUO_W'(64'd1 << (DATA_WIDTH - 1));
    localparam logic [DATA_WIDTH-1:0] Q_MAX = DATA_WIDTH'((64'd1 << (DATA_WIDTH - 1)) - 64'd1);
    localparam logic [DATA_WIDTH-1:0] Q_MIN = DATA_WIDTH'(64'd1 << (DATA_WIDTH - 1));
    localparam logic [DATA_WIDTH-1:0] Q_ONE = DATA_WIDTH'(64'd1 << FRAC_W);

    localparam logic [1:0] SLOT_X = 2'd0;
    localparam logic [1:0] SLOT_Y = 2'd1;
    localparam logic [1:0] SLOT_Z = 2'd2;
    localparam logic [1:0] SLOT_W = 2'd3;

    typedef struct packed {
        logic                              invalid;
        logic [1:0]                        big_idx;
        logic [QUATS-1:0]                  neg;
        logic [QUATS-1:0][MAG_W-1:0]       mag;
    } side_t;

    typedef struct packed {
        logic             invalid;
        logic [1:0]       big_idx;
        logic [QUATS-1:0] neg;
        logic [ROOT_W-1:0] big;
    } div_side_t;

    typedef struct packed {
        logic en;
        logic valid;
    } pipe_ctl_t;

endpackage
`default_nettype wire

@@ hdl/rmq_front.sv @@
// front stages: trace, axis choice, radicand and off-diagonal pair terms
`default_nettype none
module rmq_front
    import rmq_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire pipe_ctl_t             ctl,
    input  wire logic [IN_W-1:0]       elems,
    output logic                       out_valid,
    output logic [RAD_W-1:0]           rad,
    output side_t                      side
);

    logic signed [DATA_WIDTH-1:0] e [ELEMS];

    always_comb
    begin
        for (int n = 0; n < ELEMS; n++)
        begin
            e[n] = elems[n*DATA_WIDTH +: DATA_WIDTH];
        end
    end

    // stage a
    logic                         va_reg, va_next;
    logic signed [TR_W-1:0]       tr_reg;
    logic signed [DATA_WIDTH-1:0] e00_reg, e11_reg, e22_reg;
    logic                         gt_reg;
    logic signed [MAG_W-1:0]      d12_reg, d20_reg, d01_reg, a01_reg, a02_reg, a12_reg;

    assign va_next = ctl.en ? ctl.valid : va_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            va_reg <= 1'b0;
        end
        else
        begin
            va_reg <= va_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.en)
        begin
            tr_reg  <= TR_W'(e[0]) + TR_W'(e[4]) + TR_W'(e[8]);
            e00_reg <= e[0];
            e11_reg <= e[4];
            e22_reg <= e[8];
            gt_reg  <= e[4] > e[0];
            d12_reg <= MAG_W'(e[5]) - MAG_W'(e[7]);
            d20_reg <= MAG_W'(e[6]) - MAG_W'(e[2]);
            d01_reg <= MAG_W'(e[1]) - MAG_W'(e[3]);
            a01_reg <= MAG_W'(e[1]) + MAG_W'(e[3]);
            a02_reg <= MAG_W'(e[2]) + MAG_W'(e[6]);
            a12_reg <= MAG_W'(e[5]) + MAG_W'(e[7]);
        end
    end

    // stage b
    logic signed [DATA_WIDTH-1:0] eii_a, eii_b;
    logic                         pick_z, trace_pos, inv;
    logic [1:0]                   big_idx;
    logic signed [EXT_W-1:0]      rad_t, rad_e, rad_s;
    logic signed [MAG_W-1:0]      d [QUATS];
    side_t                        side_b;

    always_comb
    begin
        eii_a     = gt_reg ? e11_reg : e00_reg;
        pick_z    = e22_reg > eii_a;
        eii_b     = pick_z ? e22_reg : eii_a;
        trace_pos = (tr_reg != '0) && !tr_reg[TR_W-1];
        rad_t     = EXT_W'(tr_reg) + Q_ONE_X;
        rad_e     = (EXT_W'(eii_b) <<< 1) - EXT_W'(tr_reg) + Q_ONE_X;
        rad_s     = trace_pos ? rad_t : rad_e;
        inv       = !trace_pos && (rad_e[EXT_W-1] || (rad_e == '0));
        if (trace_pos)
        begin
            big_idx = SLOT_W;
        end
        else if (pick_z)
        begin
            big_idx = SLOT_Z;
        end
        else if (gt_reg)
        begin
            big_idx = SLOT_Y;
        end
        else
        begin
            big_idx = SLOT_X;
        end
        case (big_idx)
            SLOT_X:
            begin
                d[0] = '0;      d[1] = a01_reg; d[2] = a02_reg; d[3] = d12_reg;
            end
            SLOT_Y:
            begin
                d[0] = a01_reg; d[1] = '0;      d[2] = a12_reg; d[3] = d20_reg;
            end
            SLOT_Z:
            begin
                d[0] = a02_reg; d[1] = a12_reg; d[2] = '0;      d[3] = d01_reg;
            end
            default:
            begin
                d[0] = d12_reg; d[1] = d20_reg; d[2] = d01_reg; d[3] = '0;
            end
        endcase
        side_b.invalid = inv;
        side_b.big_idx = big_idx;
        for (int s = 0; s < QUATS; s++)
        begin
            side_b.neg[s] = d[s][MAG_W-1];
            side_b.mag[s] = d[s][MAG_W-1] ? MAG_W'(-d[s]) : MAG_W'(d[s]);
        end
    end

    logic                vb_reg, vb_next;
    logic [RAD_W-1:0]    rad_reg;
    side_t               side_reg;

    assign vb_next = ctl.en ? va_reg : vb_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vb_reg <= 1'b0;
        end
        else
        begin
            vb_reg <= vb_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.en)
        begin
            rad_reg  <= inv ? RAD_W'(1) : rad_s[RAD_W-1:0];
            side_reg <= side_b;
        end
    end

    assign out_valid = vb_reg;
    assign rad       = rad_reg;
    assign side      = side_reg;

endmodule
`default_nettype wire

@@ hdl/rmq_sqrt.sv @@
// pipelined integer square root, one root bit per stage
`default_nettype none
module rmq_sqrt
    import rmq_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire pipe_ctl_t         ctl,
    input  wire logic [RAD_W-1:0]  rad,
    input  wire side_t             side_in,
    output logic                   out_valid,
    output logic [ROOT_W-1:0]      root,
    output side_t                  side_out
);

    logic [SQ_REM_W-1:0] rem_q  [SQ_STEPS+1];
    logic [ROOT_W-1:0]   root_q [SQ_STEPS+1];
    logic [SQ_PAD_W-1:0] bits_q [SQ_STEPS+1];
    side_t               side_q [SQ_STEPS+1];
    logic                vld_q  [SQ_STEPS+1];

    assign rem_q[0]  = '0;
    assign root_q[0] = '0;
    assign bits_q[0] = SQ_PAD_W'(rad) << (FRAC_W - 2);
    assign side_q[0] = side_in;
    assign vld_q[0]  = ctl.valid;

    for (genvar k = 0; k < SQ_STEPS; k++)
    begin : g_step
        logic [SQ_REM_W-1:0] rem_sh, trial;
        logic                take;
        logic [SQ_REM_W-1:0] rem_reg;
        logic [ROOT_W-1:0]   root_reg;
        logic [SQ_PAD_W-1:0] bits_reg;
        side_t               side_reg;
        logic                vld_reg, vld_next;

        always_comb
        begin
            rem_sh = {rem_q[k][SQ_REM_W-3:0], bits_q[k][SQ_PAD_W-1 -: 2]};
            trial  = SQ_REM_W'({root_q[k], 2'b01});
            take   = rem_sh >= trial;
        end

        assign vld_next = ctl.en ? vld_q[k] : vld_reg;

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                vld_reg <= 1'b0;
            end
            else
            begin
                vld_reg <= vld_next;
            end
        end

        always_ff @(posedge clk)
        begin
            if (ctl.en)
            begin
                rem_reg  <= take ? rem_sh - trial : rem_sh;
                root_reg <= {root_q[k][ROOT_W-2:0], take};
                bits_reg <= bits_q[k] << 2;
                side_reg <= side_q[k];
            end
        end

        assign rem_q[k+1]  = rem_reg;
        assign root_q[k+1] = root_reg;
        assign bits_q[k+1] = bits_reg;
        assign side_q[k+1] = side_reg;
        assign vld_q[k+1]  = vld_reg;
    end

    assign out_valid = vld_q[SQ_STEPS];
    assign root      = root_q[SQ_STEPS];
    assign side_out  = side_q[SQ_STEPS];

endmodule
`default_nettype wire

@@ hdl/rmq_div.sv @@
// four-lane pipelined restoring divider with round-half-up numerator
`default_nettype none
module rmq_div
    import rmq_pkg::*;
(
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire pipe_ctl_t                    ctl,
    input  wire logic [ROOT_W-1:0]            big,
    input  wire side_t                        side_in,
    output logic                              out_valid,
    output logic [QUATS-1:0][QUO_W-1:0]       quo,
    output div_side_t                         side_out
);

    // numerator prep stage
    logic                              vp_reg, vp_next;
    logic [QUATS-1:0][NUM_W-1:0]       num_p_reg;
    logic [ROOT_W-1:0]                 den_p_reg;
    div_side_t                         side_p_reg;

    assign vp_next = ctl.en ? ctl.valid : vp_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vp_reg <= 1'b0;
        end
        else
        begin
            vp_reg <= vp_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.en)
        begin
            for (int s = 0; s < QUATS; s++)
            begin
                num_p_reg[s] <= (NUM_W'(side_in.mag[s]) << (FRAC_W - 2))
                                + NUM_W'(big >> 1);
            end
            den_p_reg          <= (big == '0) ? ROOT_W'(1) : big;
            side_p_reg.invalid <= side_in.invalid;
            side_p_reg.big_idx <= side_in.big_idx;
            side_p_reg.neg     <= side_in.neg;
            side_p_reg.big     <= big;
        end
    end

    logic [QUATS-1:0][DREM_W-1:0] rem_q  [QUO_W+1];
    logic [QUATS-1:0][QUO_W-1:0]  quo_q  [QUO_W+1];
    logic [QUATS-1:0][NUM_W-1:0]  num_q  [QUO_W+1];
    logic [ROOT_W-1:0]            den_q  [QUO_W+1];
    div_side_t                    side_q [QUO_W+1];
    logic                         vld_q  [QUO_W+1];

    assign rem_q[0]  = '0;
    assign quo_q[0]  = '0;
    assign num_q[0]  = num_p_reg;
    assign den_q[0]  = den_p_reg;
    assign side_q[0] = side_p_reg;
    assign vld_q[0]  = vp_reg;

    for (genvar k = 0; k < QUO_W; k++)
    begin : g_step
        logic [QUATS-1:0][DREM_W-1:0] rem_sh, rem_n;
        logic [QUATS-1:0]             ge;
        logic [QUATS-1:0][DREM_W-1:0] rem_reg;
        logic [QUATS-1:0][QUO_W-1:0]  quo_reg;
        logic [QUATS-1:0][NUM_W-1:0]  num_reg;
        logic [ROOT_W-1:0]            den_reg;
        div_side_t                    side_reg;
        logic                         vld_reg, vld_next;

        always_comb
        begin
            for (int s = 0; s < QUATS; s++)
            begin
                rem_sh[s] = {rem_q[k][s][DREM_W-2:0], num_q[k][s][NUM_W-1]};
                ge[s]     = rem_sh[s] >= DREM_W'(den_q[k]);
                rem_n[s]  = ge[s] ? rem_sh[s] - DREM_W'(den_q[k]) : rem_sh[s];
            end
        end

        assign vld_next = ctl.en ? vld_q[k] : vld_reg;

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                vld_reg <= 1'b0;
            end
            else
            begin
                vld_reg <= vld_next;
            end
        end

        always_ff @(posedge clk)
        begin
            if (ctl.en)
            begin
                for (int s = 0; s < QUATS; s++)
                begin
                    rem_reg[s] <= rem_n[s];
                    quo_reg[s] <= {quo_q[k][s][QUO_W-2:0], ge[s]};
                    num_reg[s] <= num_q[k][s] << 1;
                end
                den_reg  <= den_q[k];
                side_reg <= side_q[k];
            end
        end

        assign rem_q[k+1]  = rem_reg;
        assign quo_q[k+1]  = quo_reg;
        assign num_q[k+1]  = num_reg;
        assign den_q[k+1]  = den_reg;
        assign side_q[k+1] = side_reg;
        assign vld_q[k+1]  = vld_reg;
    end

    assign out_valid = vld_q[QUO_W];
    assign quo       = quo_q[QUO_W];
    assign side_out  = side_q[QUO_W];

endmodule
`default_nettype wire

@@ hdl/rotation_matrix_to_quaternion.sv @@
// top level: rotation matrix to unit quaternion, fully pipelined
//
// channel | dir | fields
// s_*     | in  | tdata: elem_00 .. elem_22, 16 bits each
// m_*     | out | tdata: quat_x, quat_y, quat_z, quat_w; tuser: invalid
//
// one request per cycle while the stages advance; the path runs through the front stages,
// 15 square root stages, a divider prep stage, 30 divider stages and an output register
// all stages advance together; they hold only when the last stage and the
// output register are both full and the output is not taken
// reset clears every valid bit; no clearing pass is needed
`default_nettype none
module rotation_matrix_to_quaternion
    import rmq_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              s_tvalid,
    output logic                   s_tready,
    input  wire logic [IN_W-1:0]   s_tdata,   // elem_00, 01, 02, 10, 11, 12, 20, 21, 22
    output logic                   m_tvalid,
    input  wire logic              m_tready,
    output logic [OUT_W-1:0]       m_tdata,   // quat_x, quat_y, quat_z, quat_w
    output logic                   m_tuser    // invalid
);

    logic                          en;
    logic                          f_valid, s_valid, d_valid;
    logic [RAD_W-1:0]              rad;
    side_t                         f_side, s_side;
    logic [ROOT_W-1:0]             root;
    logic [QUATS-1:0][QUO_W-1:0]   quo;
    div_side_t                     d_side;
    pipe_ctl_t                     ctl_f, ctl_s, ctl_d;

    logic                          out_valid_reg, out_valid_next;
    logic [OUT_W-1:0]              out_data_reg;
    logic                          out_inv_reg;

    assign en       = !(d_valid && out_valid_reg && !m_tready);
    assign s_tready = en;

    assign ctl_f = '{en: en, valid: s_tvalid};
    assign ctl_s = '{en: en, valid: f_valid};
    assign ctl_d = '{en: en, valid: s_valid};

    rmq_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctl       (ctl_f),
        .elems     (s_tdata),
        .out_valid (f_valid),
        .rad       (rad),
        .side      (f_side)
    );

    rmq_sqrt u_sqrt (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctl       (ctl_s),
        .rad       (rad),
        .side_in   (f_side),
        .out_valid (s_valid),
        .root      (root),
        .side_out  (s_side)
    );

    rmq_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctl       (ctl_d),
        .big       (root),
        .side_in   (s_side),
        .out_valid (d_valid),
        .quo       (quo),
        .side_out  (d_side)
    );

    // saturate, sign and place each component; an invalid result gives the identity
    logic [OUT_W-1:0] comp;

    always_comb
    begin
        for (int s = 0; s < QUATS; s++)
        begin
            if (d_side.invalid)
            begin
                comp[s*DATA_WIDTH +: DATA_WIDTH] = (2'(s) == SLOT_W) ? Q_ONE : '0;
            end
            else if (2'(s) == d_side.big_idx)
            begin
                comp[s*DATA_WIDTH +: DATA_WIDTH] = DATA_WIDTH'(d_side.big);
            end
            else if (d_side.neg[s])
            begin
                comp[s*DATA_WIDTH +: DATA_WIDTH] = (quo[s] > Q_MIN_U) ? Q_MIN
                                                 : DATA_WIDTH'(-quo[s]);
            end
            else
            begin
                comp[s*DATA_WIDTH +: DATA_WIDTH] = (quo[s] > Q_MAX_U) ? Q_MAX
                                                 : DATA_WIDTH'(quo[s]);
            end
        end
    end

    always_comb
    begin
        if (en && d_valid)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en && d_valid)
        begin
            out_data_reg <= comp;
            out_inv_reg  <= d_side.invalid;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tuser  = out_inv_reg;

`ifndef SYNTHESIS
    a_invalid_identity: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tuser) |-> (m_tdata == {Q_ONE, {(OUT_W - DATA_WIDTH){1'b0}}}))
        else $error("invalid result is not the identity");

    a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !m_tvalid |-> s_tready)
        else $error("input stalled with empty output");

    a_stall_holds_output: assert property (@(posedge clk) disable iff (!rst_n)
        !s_tready |-> (m_tvalid && !m_tready))
        else $error("pipeline stalled without back pressure");
`endif

endmodule
`default_nettype wire
